/* sv/prrts_pkg.sv */
package prrts_pkg;

    // Event codes carried in the action field.
    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_TICK    = 3'd1,
        ACT_READY   = 3'd2,
        ACT_SUSPEND = 3'd3,
        ACT_WAIT    = 3'd4,
        ACT_YIELD   = 3'd5
    } t_action;

    // Error codes reported on the result channel.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_STATE   = 2'd2;
    localparam logic [1:0] ERR_TIMER   = 2'd3;

    // Register index of the priority word.
    localparam int REG_PRIO = 0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;   // latch the accepted item
        logic       clr_all;     // start: clear timers, list to idle only
        logic       ins_task;    // insert task held in the work register
        logic       rem_task;    // remove task held in the work register
        logic       set_timer;   // timer of current task := timeout
        logic       dec_timer;   // decrement timer at scan index
        logic       set_cur_head;// current := head of list
        logic       sched;       // run the scheduler rule
        logic       work_scan;   // work register := next scan index
        logic       work_req;    // work register := task_req
        logic       work_cur;    // work register := current task
        logic       scan_clr;    // scan index := 0
        logic       scan_inc;    // scan index += 1
        logic       scan_top;    // scan index := TASKS
        logic       scan_dec;    // scan index -= 1
        logic       set_start;   // started := 1
        logic       set_halt;    // record error code
        logic [1:0] halt_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action    action;
        logic [7:0] timeout;
        logic       req_valid;   // task_req is 1..TASKS
        logic       cur_valid;   // current task is 1..TASKS
        logic       work_listed; // work task is in the list
        logic       cur_timer_nz;// current task's timer is nonzero
        logic       scan_nz;     // timer at scan index is nonzero
        logic       scan_one;    // timer at scan index equals one
        logic       scan_valid;  // scan index is 1..TASKS
        logic       scan_last;   // scan index is TASKS
        logic       scan_zero;   // scan index is 0
        logic       started;
        logic       halted;
    } t_stat;

endpackage

/* sv/prrts_if.sv */
interface prrts_if #(
    parameter int W = 8
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/priority_round_robin_task_scheduler_core.sv */
// Fixed-priority round-robin task scheduler. Each event takes one item and
// returns one result; the block works on one event at a time. Start inserts
// one task per cycle into the list and then picks the head; tick handles one
// timer per cycle and then runs a scheduling step. Make_ready, suspend and
// suspend_and_wait with a nonzero timeout pass from decode through a finish
// state to the result; yield, a zero timeout, unused codes and any event while
// halted go from decode straight to the result. After a result transfer the
// block returns to idle before it takes the next input transfer, and a stalled
// result holds the input off. The pace is set by handling one list entry or
// one timer per cycle. Priorities are written through the APB port at address 0
// by the user while the block is idle; the block itself does not enforce this.
module priority_round_robin_task_scheduler_core #(
    parameter int TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prrts_if.sink       i_in,
    prrts_if.source     o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    prrts_pkg::t_cmd  w_cmd;
    prrts_pkg::t_stat w_stat;
    logic [63:0]      r_prio;
    logic             w_out_valid;

    // Priority register write and readback.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= 64'd0;
        end else if (psel && penable && pwrite && paddr == 3'(prrts_pkg::REG_PRIO * 8)) begin
            r_prio <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'(prrts_pkg::REG_PRIO * 8)) ? r_prio : 64'd0;

    prrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    prrts_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_in.data[2:0]),
        .i_task_req     (i_in.data[6:3]),
        .i_timeout      (i_in.data[14:7]),
        .i_prio         (r_prio),
        .o_running_task (o_out.data[3:0]),
        .o_halted       (o_out.data[4]),
        .o_error_code   (o_out.data[6:5]),
        .o_ready_count  (o_out.data[10:7])
    );

    assign o_out.valid = w_out_valid;

endmodule

/* sv/prrts_ctrl.sv */
module prrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  prrts_pkg::t_stat  i_stat,
    output prrts_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_TICK,
        S_SCHED,
        S_FINISH,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    // Sequencer: one event at a time.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (!i_stat.halted) begin
                    case (i_stat.action)
                        prrts_pkg::ACT_START: begin
                            o_cmd.clr_all   = 1'b1;
                            o_cmd.scan_top  = 1'b1;
                            o_cmd.work_scan = 1'b1;
                            n_state         = S_START;
                        end
                        prrts_pkg::ACT_TICK: begin
                            o_cmd.scan_clr  = 1'b1;
                            o_cmd.work_scan = 1'b1;
                            n_state         = S_TICK;
                        end
                        prrts_pkg::ACT_READY: begin
                            o_cmd.work_req = 1'b1;
                            n_state        = S_FINISH;
                        end
                        prrts_pkg::ACT_SUSPEND: begin
                            o_cmd.work_req = 1'b1;
                            n_state        = S_FINISH;
                        end
                        prrts_pkg::ACT_WAIT: begin
                            o_cmd.work_cur = 1'b1;
                            if (i_stat.timeout != 8'd0) begin
                                n_state = S_FINISH;
                            end
                        end
                        prrts_pkg::ACT_YIELD: begin
                            o_cmd.sched = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                // Insert tasks from TASKS down to 1, then pick the head.
                if (i_stat.scan_zero) begin
                    o_cmd.set_cur_head = 1'b1;
                    o_cmd.set_start    = 1'b1;
                    n_state            = S_OUT;
                end else begin
                    o_cmd.ins_task  = 1'b1;
                    o_cmd.scan_dec  = 1'b1;
                    o_cmd.work_scan = 1'b1;
                end
            end
            S_TICK: begin
                // One timer per cycle, in increasing id order.
                if (i_stat.scan_nz && i_stat.scan_one && !i_stat.scan_valid) begin
                    o_cmd.dec_timer = 1'b1;
                    o_cmd.set_halt  = 1'b1;
                    o_cmd.halt_code = prrts_pkg::ERR_INVALID;
                    n_state         = S_OUT;
                end else if (i_stat.scan_nz && i_stat.scan_one && i_stat.work_listed) begin
                    o_cmd.dec_timer = 1'b1;
                    o_cmd.set_halt  = 1'b1;
                    o_cmd.halt_code = prrts_pkg::ERR_STATE;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.dec_timer = i_stat.scan_nz;
                    o_cmd.ins_task  = i_stat.scan_nz && i_stat.scan_one;
                    if (i_stat.scan_last) begin
                        n_state = S_SCHED;
                    end else begin
                        o_cmd.work_scan = 1'b1;
                        o_cmd.scan_inc  = 1'b1;
                    end
                end
            end
            S_SCHED: begin
                // If started, pick the next task once every expired timer has been listed.
                o_cmd.sched = i_stat.started;
                n_state     = S_OUT;
            end
            S_FINISH: begin
                n_state = S_OUT;
                case (i_stat.action)
                    prrts_pkg::ACT_READY: begin
                        if (!i_stat.req_valid) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_INVALID;
                        end else if (i_stat.work_listed) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_STATE;
                        end else begin
                            o_cmd.ins_task = 1'b1;
                        end
                    end
                    prrts_pkg::ACT_SUSPEND: begin
                        if (!i_stat.req_valid) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_INVALID;
                        end else if (!i_stat.work_listed) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_STATE;
                        end else begin
                            o_cmd.rem_task = 1'b1;
                        end
                    end
                    default: begin
                        // Suspend and wait on the current task.
                        if (i_stat.cur_timer_nz) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_TIMER;
                        end else if (!i_stat.cur_valid) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_INVALID;
                        end else if (!i_stat.work_listed) begin
                            o_cmd.set_halt  = 1'b1;
                            o_cmd.halt_code = prrts_pkg::ERR_STATE;
                        end else begin
                            o_cmd.set_timer = 1'b1;
                            o_cmd.rem_task  = 1'b1;
                            o_cmd.sched     = 1'b1;
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // A result appears only after an accepted item.
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result without an item");
    // Input is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");
    // Item load happens only from idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |-> o_in_ready)
        else $error("load outside idle");

endmodule

/* sv/prrts_dp.sv */
module prrts_dp #(
    parameter int TASKS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prrts_pkg::t_cmd   i_cmd,
    output prrts_pkg::t_stat  o_stat,
    input  logic [2:0]        i_action,
    input  logic [3:0]        i_task_req,
    input  logic [7:0]        i_timeout,
    input  logic [63:0]       i_prio,
    output logic [3:0]        o_running_task,
    output logic              o_halted,
    output logic [1:0]        o_error_code,
    output logic [3:0]        o_ready_count
);

    localparam int SLOTS = TASKS + 1;
    localparam int LW    = $clog2(SLOTS + 1);

    logic [3:0]    r_order [SLOTS];
    logic [LW-1:0] r_len;
    logic [7:0]    r_timer [SLOTS];
    logic [3:0]    r_cur;
    logic          r_started;
    logic [1:0]    r_halt;
    logic [2:0]    r_action;
    logic [3:0]    r_req;
    logic [7:0]    r_tmo;
    logic [3:0]    r_work;
    logic [3:0]    r_scan;
    logic [3:0]    n_scan;

    // Priority of a task id; idle and ids above eight or above TASKS read as zero.
    function automatic logic [7:0] prio_of(input logic [3:0] id, input logic [63:0] p);
        logic [7:0] v;
        v = 8'd0;
        if (id != 4'd0 && id <= 4'd8 && 32'(id) <= TASKS) begin
            v = p[8*(id-4'd1) +: 8];
        end
        return v;
    endfunction

    logic [SLOTS-1:0] w_match;
    logic [SLOTS-1:0] w_lower;
    logic [SLOTS-1:0] w_curm;
    logic [LW-1:0]    w_ipos;
    logic [LW-1:0]    w_rpos;
    logic [LW-1:0]    w_cpos;
    logic             w_listed;
    logic             w_cfound;
    logic [3:0]       w_next;
    logic [7:0]       w_wp;

    // Compare every list slot against the work task and the current task.
    always_comb begin
        w_wp   = prio_of(r_work, i_prio);
        w_ipos = r_len - LW'(1);
        w_rpos = '0;
        w_cpos = '0;
        w_listed = 1'b0;
        w_cfound = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            w_match[i] = (LW'(i) < r_len) && (r_order[i] == r_work);
            w_curm[i]  = (LW'(i) < r_len) && (r_order[i] == r_cur);
            w_lower[i] = (LW'(i) < r_len) && (w_wp > prio_of(r_order[i], i_prio));
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_rpos   = LW'(i);
                w_listed = 1'b1;
            end
            if (w_curm[i]) begin
                w_cpos   = LW'(i);
                w_cfound = 1'b1;
            end
            if (w_lower[i] && LW'(i) < r_len - LW'(1)) begin
                w_ipos = LW'(i);
            end
        end
        w_next = r_order[0];
        if (w_cfound && (w_cpos + LW'(1) < r_len)) begin
            if (prio_of(r_order[w_cpos], i_prio) ==
                prio_of(r_order[w_cpos + LW'(1)], i_prio)) begin
                w_next = r_order[w_cpos + LW'(1)];
            end
        end
    end

    // Next scan index.
    always_comb begin
        n_scan = r_scan;
        if (i_cmd.scan_clr) begin
            n_scan = 4'd0;
        end else if (i_cmd.scan_top) begin
            n_scan = 4'(TASKS);
        end else if (i_cmd.scan_inc) begin
            n_scan = r_scan + 4'd1;
        end else if (i_cmd.scan_dec) begin
            n_scan = r_scan - 4'd1;
        end
    end

    // Item latch, work register and scan counter; the work register can follow the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_req    <= i_task_req;
            r_tmo    <= i_timeout;
        end
        if (i_cmd.work_req) begin
            r_work <= r_req;
        end else if (i_cmd.work_cur) begin
            r_work <= r_cur;
        end else if (i_cmd.work_scan) begin
            r_work <= n_scan;
        end
        r_scan <= n_scan;
    end

    logic w_scan_hit;
    assign w_scan_hit = (r_scan == r_work);

    // List, timers and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LW'(1);
            r_order[0] <= 4'd0;
            r_cur      <= 4'd0;
            r_started  <= 1'b0;
            r_halt     <= prrts_pkg::ERR_NONE;
            for (int i = 0; i < SLOTS; i++) begin
                r_timer[i] <= 8'd0;
            end
        end else begin
            if (i_cmd.clr_all) begin
                r_len      <= LW'(1);
                r_order[0] <= 4'd0;
                for (int i = 0; i < SLOTS; i++) begin
                    r_timer[i] <= 8'd0;
                end
            end
            if (i_cmd.dec_timer) begin
                r_timer[r_scan] <= r_timer[r_scan] - 8'd1;
            end
            if (i_cmd.set_timer) begin
                r_timer[r_cur] <= r_tmo;
            end
            if (i_cmd.ins_task && 32'(r_len) < SLOTS) begin
                if (!i_cmd.dec_timer || !w_scan_hit) begin
                    r_timer[r_work] <= 8'd0;
                end
                for (int i = 1; i < SLOTS; i++) begin
                    if (LW'(i) > w_ipos && LW'(i) <= r_len) begin
                        r_order[i] <= r_order[i-1];
                    end
                end
                r_order[w_ipos] <= r_work;
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.rem_task) begin
                for (int i = 0; i < SLOTS - 1; i++) begin
                    if (LW'(i) >= w_rpos) begin
                        r_order[i] <= r_order[i+1];
                    end
                end
                r_len <= r_len - LW'(1);
            end
            if (i_cmd.sched) begin
                if (i_cmd.rem_task) begin
                    // Removal and scheduling share a cycle: the removed task
                    // was current, so the head of the shortened list runs.
                    if (w_rpos != '0) begin
                        r_cur <= r_order[0];
                    end else begin
                        r_cur <= r_order[1];
                    end
                end else begin
                    r_cur <= w_next;
                end
            end
            if (i_cmd.set_cur_head) begin
                r_cur <= r_order[0];
            end
            if (i_cmd.set_start) begin
                r_started <= 1'b1;
            end
            if (i_cmd.set_halt) begin
                r_halt <= i_cmd.halt_code;
            end
        end
    end

    logic [7:0] w_scan_tmr;
    assign w_scan_tmr = (32'(r_scan) < SLOTS) ? r_timer[r_scan] : 8'd0;

    always_comb begin
        o_stat.action       = prrts_pkg::t_action'(r_action);
        o_stat.timeout      = r_tmo;
        o_stat.req_valid    = (r_req != 4'd0) && (32'(r_req) <= TASKS);
        o_stat.cur_valid    = (r_cur != 4'd0) && (32'(r_cur) <= TASKS);
        o_stat.work_listed  = w_listed;
        o_stat.cur_timer_nz = (32'(r_cur) < SLOTS) ? (r_timer[r_cur] != 8'd0) : 1'b0;
        o_stat.scan_nz      = (w_scan_tmr != 8'd0);
        o_stat.scan_one     = (w_scan_tmr == 8'd1);
        o_stat.scan_valid   = (r_scan != 4'd0) && (32'(r_scan) <= TASKS);
        o_stat.scan_last    = (32'(r_scan) == TASKS);
        o_stat.scan_zero    = (r_scan == 4'd0);
        o_stat.started      = r_started;
        o_stat.halted       = (r_halt != prrts_pkg::ERR_NONE);
    end

    assign o_running_task = r_cur;
    assign o_halted       = (r_halt != prrts_pkg::ERR_NONE);
    assign o_error_code   = r_halt;
    assign o_ready_count  = 4'(r_len);

    // The list always holds at least the idle task.
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0)
        else $error("ready list empty");
    // Halt is sticky.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt != prrts_pkg::ERR_NONE) |=> (r_halt == $past(r_halt)))
        else $error("halt code changed");
    // Insert and remove are never issued together.
    a_one_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.ins_task && i_cmd.rem_task))
        else $error("insert and remove together");

endmodule

/* sim/prrts_checker.sv */
`timescale 1ns / 100ps

// Watches the event and result channels and the priority register writes,
// predicts each scheduler result and compares it with what the block returns.
module prrts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [14:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [10:0] i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output logic [8:0]  o_listed,
    output logic [3:0]  o_cur,
    output logic        o_halted
);

    localparam int NTASK = 8;
    localparam int NSLOT = NTASK + 1;

    // Result word layout, most significant field first.
    typedef struct packed {
        logic [3:0] count;
        logic [1:0] err;
        logic       halted;
        logic [3:0] running;
    } t_sched_res;

    // Shadow copy of the scheduler state.
    logic [63:0] prio_word;
    logic [3:0]  order [0:NSLOT-1];
    int          len;
    logic [7:0]  timer [0:NSLOT-1];
    logic [3:0]  cur;
    logic        started;
    logic [1:0]  halt;

    t_sched_res  sched_results [$];

    function automatic logic [7:0] prio_of(input logic [3:0] id);
        if (id == 0 || id > NTASK) return 8'd0;
        return prio_word[8*(id-1) +: 8];
    endfunction

    function automatic int find_pos(input logic [3:0] id);
        for (int i = 0; i < len; i++)
            if (order[i] == id) return i;
        return len;
    endfunction

    function automatic void insert_task(input logic [3:0] id);
        logic [7:0] p;
        int i;
        p = prio_of(id);
        if (len >= NSLOT) return;
        timer[id] = 8'd0;
        for (i = 0; i < len; i++)
            if (p > prio_of(order[i]) || i + 1 == len) break;
        for (int j = len; j > i; j--) order[j] = order[j-1];
        order[i] = id;
        len++;
    endfunction

    function automatic void remove_at(input int pos);
        if (pos >= len) return;
        for (int j = pos; j < len - 1; j++) order[j] = order[j+1];
        len--;
    endfunction

    // Equal-priority successor of the current task, else the list head.
    function automatic void pick_next();
        int pos;
        pos = find_pos(cur);
        if (pos + 1 < len && prio_of(order[pos]) == prio_of(order[pos+1]))
            cur = order[pos+1];
        else
            cur = order[0];
    endfunction

    function automatic logic task_ok(input logic [3:0] id);
        return id >= 1 && id <= NTASK;
    endfunction

    function automatic t_sched_res apply_event(input logic [2:0] act, input logic [3:0] req,
                                               input logic [7:0] tmo);
        t_sched_res r;
        if (halt == prrts_pkg::ERR_NONE) begin
            case (act)
                prrts_pkg::ACT_START: begin
                    for (int n = 0; n < NSLOT; n++) timer[n] = 8'd0;
                    order[0] = 4'd0;
                    len = 1;
                    for (int n = NTASK; n >= 1; n--) insert_task(4'(n));
                    cur = order[0];
                    started = 1'b1;
                end
                prrts_pkg::ACT_TICK: begin
                    for (int n = 0; n < NSLOT; n++) begin
                        if (timer[n] != 0) begin
                            timer[n] = timer[n] - 8'd1;
                            if (timer[n] == 0) begin
                                if (!task_ok(4'(n))) begin
                                    halt = prrts_pkg::ERR_INVALID;
                                    break;
                                end
                                if (find_pos(4'(n)) < len) begin
                                    halt = prrts_pkg::ERR_STATE;
                                    break;
                                end
                                insert_task(4'(n));
                            end
                        end
                    end
                    if (halt == prrts_pkg::ERR_NONE && started) pick_next();
                end
                prrts_pkg::ACT_READY: begin
                    if (!task_ok(req)) halt = prrts_pkg::ERR_INVALID;
                    else if (find_pos(req) < len) halt = prrts_pkg::ERR_STATE;
                    else insert_task(req);
                end
                prrts_pkg::ACT_SUSPEND: begin
                    if (!task_ok(req)) halt = prrts_pkg::ERR_INVALID;
                    else if (find_pos(req) >= len) halt = prrts_pkg::ERR_STATE;
                    else remove_at(find_pos(req));
                end
                prrts_pkg::ACT_WAIT: begin
                    if (tmo != 0) begin
                        if (cur >= NSLOT) halt = prrts_pkg::ERR_INVALID;
                        else if (timer[cur] != 0) halt = prrts_pkg::ERR_TIMER;
                        else if (!task_ok(cur)) halt = prrts_pkg::ERR_INVALID;
                        else if (find_pos(cur) >= len) halt = prrts_pkg::ERR_STATE;
                        else begin
                            timer[cur] = tmo;
                            remove_at(find_pos(cur));
                            pick_next();
                        end
                    end
                end
                prrts_pkg::ACT_YIELD: pick_next();
                default: ;
            endcase
        end
        r.running = cur;
        r.halted  = (halt != prrts_pkg::ERR_NONE);
        r.err     = halt;
        r.count   = 4'(len);
        return r;
    endfunction

    function automatic logic [8:0] listed_mask();
        logic [8:0] m;
        m = '0;
        for (int i = 0; i < len; i++) m[order[i]] = 1'b1;
        return m;
    endfunction

    // Predict on each event transfer, compare on each result transfer.
    always @(posedge i_clk) begin
        t_sched_res got;
        t_sched_res want;
        if (!i_rst_n) begin
            prio_word = '0;
            for (int n = 0; n < NSLOT; n++) begin
                order[n] = 4'd0;
                timer[n] = 8'd0;
            end
            len = 1;
            cur = 4'd0;
            started = 1'b0;
            halt = prrts_pkg::ERR_NONE;
            sched_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_paddr == 3'(8 * prrts_pkg::REG_PRIO))
                prio_word = i_pwdata;
            if (i_in_valid && i_in_ready)
                sched_results.push_back(apply_event(i_in_data[2:0], i_in_data[6:3],
                                                    i_in_data[14:7]));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (sched_results.size() == 0) begin
                    $error("result transfer with no event outstanding: %h", got);
                    o_fail_count++;
                end else begin
                    want = sched_results.pop_front();
                    if (got.running !== want.running) begin
                        $error("running_task expected %0d got %0d", want.running, got.running);
                        o_fail_count++;
                    end
                    if (got.halted !== want.halted) begin
                        $error("halted expected %0d got %0d", want.halted, got.halted);
                        o_fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_code expected %0d got %0d", want.err, got.err);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("ready_count expected %0d got %0d", want.count, got.count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = sched_results.size();
        o_listed  = listed_mask();
        o_cur     = cur;
        o_halted  = (halt != prrts_pkg::ERR_NONE);
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    // Kinds of generated events.
    localparam int K_START = 0;
    localparam int K_TICK  = 1;
    localparam int K_READY = 2;
    localparam int K_SUSP  = 3;
    localparam int K_WAIT  = 4;
    localparam int K_WAIT0 = 5;
    localparam int K_YIELD = 6;
    localparam int K_NOISE = 7;

    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    prrts_if #(.W(15)) in_ch (i_clk);
    prrts_if #(.W(11)) out_ch (i_clk);

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic [8:0]  listed;
    logic [3:0]  cur_task;
    logic        halted;

    int          idle_mode = MODE_NONE;
    int          event_count [0:7];
    int          cfg_writes = 0;

    priority_round_robin_task_scheduler_core #(.TASKS(8)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    prrts_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_listed     (listed),
        .o_cur        (cur_task),
        .o_halted     (halted)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Result side stalls according to the current idle mode.
    always @(posedge i_clk) begin
        case (idle_mode)
            MODE_RECV: out_ch.ready <= ($urandom_range(0, 99) >= 49);
            MODE_BOTH: out_ch.ready <= ($urandom_range(0, 99) >= 16);
            default:   out_ch.ready <= 1'b1;
        endcase
    end

    initial begin
        #4000000;
        $display("priority_round_robin_task_scheduler_core verification failed");
        $finish;
    end

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_prio(input logic [63:0] value);
        wait_drained();
        repeat (24) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(8 * prrts_pkg::REG_PRIO);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // One event transfer, with sender gaps when the mode asks for them.
    task automatic send_event(input logic [2:0] act, input logic [3:0] req,
                              input logic [7:0] tmo);
        int pct;
        pct = (idle_mode == MODE_SEND) ? 49 : (idle_mode == MODE_BOTH) ? 16 : 0;
        @(posedge i_clk);
        while ($urandom_range(0, 99) < pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= {tmo, req, act};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 1'b0;
        event_count[act]++;
    endtask

    function automatic logic [3:0] pick_task(input logic [8:0] mask, input logic want);
        logic [3:0] c [$];
        for (int t = 1; t <= 8; t++)
            if (mask[t] == want) c.push_back(4'(t));
        if (c.size() == 0) return 4'd0;
        return c[$urandom_range(0, c.size() - 1)];
    endfunction

    // Issue an event of the given kind that keeps the scheduler out of error;
    // kinds that cannot be issued legally now fall back to a yield.
    task automatic issue_legal(input int kind);
        logic [3:0] t;
        logic [7:0] tmo;
        wait_drained();
        case (kind)
            K_START: send_event(prrts_pkg::ACT_START, 4'($urandom), 8'($urandom));
            K_TICK:  send_event(prrts_pkg::ACT_TICK, 4'($urandom), 8'($urandom));
            K_READY: begin
                t = pick_task(listed, 1'b0);
                if (t != 0) send_event(prrts_pkg::ACT_READY, t, 8'($urandom));
                else send_event(prrts_pkg::ACT_YIELD, 4'($urandom), 8'($urandom));
            end
            K_SUSP: begin
                t = pick_task(listed, 1'b1);
                if (t != 0) send_event(prrts_pkg::ACT_SUSPEND, t, 8'($urandom));
                else send_event(prrts_pkg::ACT_YIELD, 4'($urandom), 8'($urandom));
            end
            K_WAIT: begin
                tmo = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(1, 6));
                if (cur_task >= 1 && cur_task <= 8 && listed[cur_task])
                    send_event(prrts_pkg::ACT_WAIT, 4'($urandom), tmo);
                else
                    send_event(prrts_pkg::ACT_YIELD, 4'($urandom), 8'($urandom));
            end
            K_WAIT0: send_event(prrts_pkg::ACT_WAIT, 4'($urandom), 8'd0);
            K_NOISE: send_event(3'($urandom_range(6, 7)), 4'($urandom), 8'($urandom));
            default: send_event(prrts_pkg::ACT_YIELD, 4'($urandom), 8'($urandom));
        endcase
    endtask

    function automatic int random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return K_START;
        if (r < 32) return K_TICK;
        if (r < 50) return K_READY;
        if (r < 62) return K_SUSP;
        if (r < 80) return K_WAIT;
        if (r < 85) return K_WAIT0;
        if (r < 96) return K_YIELD;
        return K_NOISE;
    endfunction

    // Stimulus: directed opening, random phases over several priority settings,
    // then one deliberate misuse and eight more events while halted.
    initial begin
        logic [63:0] settings [0:4];
        int directed [0:21];
        int fault;
        logic [3:0] t;
        settings[0] = 64'h0303_0202_0101_0505;
        settings[1] = 64'h0;
        settings[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        settings[3] = {$urandom, $urandom};
        settings[4] = 64'h0807_0605_0403_0201;
        directed = '{K_YIELD, K_TICK, K_READY, K_START, K_YIELD, K_WAIT, K_TICK, K_WAIT,
                     K_WAIT0, K_TICK, K_TICK, K_SUSP, K_SUSP, K_READY, K_YIELD, K_NOISE,
                     K_NOISE, K_WAIT, K_READY, K_TICK, K_START, K_YIELD};
        for (int a = 0; a < 8; a++) event_count[a] = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_prio(settings[0]);
        foreach (directed[i]) issue_legal(directed[i]);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) write_prio(settings[ph]);
            issue_legal(K_START);
            for (int n = 0; n < 316; n++) begin
                idle_mode = (n / 40) % 4;
                if (n == 150) begin
                    wait_drained();
                    repeat (30) @(posedge i_clk);
                end
                issue_legal(random_kind());
            end
        end

        // One misuse halts the scheduler for the rest of the run.
        idle_mode = MODE_BOTH;
        wait_drained();
        fault = $urandom_range(0, 3);
        case (fault)
            0: send_event($urandom_range(0, 1) ? prrts_pkg::ACT_READY : prrts_pkg::ACT_SUSPEND,
                          $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15)),
                          8'($urandom));
            1: begin
                t = pick_task(listed, 1'b1);
                if (t != 0) send_event(prrts_pkg::ACT_READY, t, 8'($urandom));
                else send_event(prrts_pkg::ACT_READY, 4'd0, 8'($urandom));
            end
            2: begin
                t = pick_task(listed, 1'b0);
                if (t != 0) send_event(prrts_pkg::ACT_SUSPEND, t, 8'($urandom));
                else send_event(prrts_pkg::ACT_SUSPEND, 4'd15, 8'($urandom));
            end
            default: begin
                if (cur_task >= 1 && cur_task <= 8 && listed[cur_task]) begin
                    send_event(prrts_pkg::ACT_SUSPEND, cur_task, 8'($urandom));
                    wait_drained();
                end
                send_event(prrts_pkg::ACT_WAIT, 4'($urandom), 8'($urandom_range(1, 255)));
            end
        endcase
        for (int n = 0; n < 8; n++) issue_legal(random_kind());

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d starts, %0d ticks, %0d make_ready, %0d suspends,",
                 event_count[0], event_count[1], event_count[2], event_count[3]);
        $display("%0d waits, %0d yields, %0d unused codes, %0d priority writes, halted=%0d",
                 event_count[4], event_count[5], event_count[6] + event_count[7],
                 cfg_writes, halted);
        if (fail_count == 0) begin
            $display("priority_round_robin_task_scheduler_core verification clean");
        end else begin
            $display("priority_round_robin_task_scheduler_core verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/prrts_pkg.sv
sv/prrts_if.sv
sv/prrts_ctrl.sv
sv/prrts_dp.sv
sv/priority_round_robin_task_scheduler_core.sv
sim/prrts_checker.sv
sim/tb.sv
